// ===== hdl/tgbc_pkg.sv =====
`default_nettype none
package tgbc_pkg;

    localparam int DIM_W    = 9;
    localparam int COORD_W  = 32;
    localparam int TSIZE_W  = 31;
    localparam int MAPDIM_W = 7;
    localparam int CELL_W   = 8;
    localparam int TILE_W   = 11;
    localparam int NUM_W    = 33;
    localparam int QUO_W    = 34;
    localparam int WIDE_W   = 42;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    typedef enum logic [2:0] {
        ACT_WR_TILE  = 3'd0,
        ACT_WR_SOLID = 3'd1,
        ACT_RD_TILE  = 3'd2,
        ACT_RD_BLOCK = 3'd3,
        ACT_BOX      = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_TILE_WIDTH  = 3'd2,
        CFG_TILE_HEIGHT = 3'd3,
        CFG_MAP_WIDTH   = 3'd4,
        CFG_MAP_HEIGHT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_OP,
        ST_RD_DONE,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_CLAMP,
        ST_CELL_ADDR,
        ST_CELL_READ,
        ST_CELL_CHECK,
        ST_RESULT
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/tgbc_div.sv =====
`default_nettype none
module tgbc_div (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic signed [tgbc_pkg::NUM_W-1:0]      i_num,
    input  wire logic        [tgbc_pkg::TSIZE_W-1:0]    i_den,
    output logic                                        o_done,
    output logic signed      [tgbc_pkg::QUO_W-1:0]      o_quo
);
    import tgbc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   r_mag, n_mag;
    logic [TSIZE_W-1:0] r_rem, n_rem;
    logic [TSIZE_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [TSIZE_W:0]   shifted;
    logic [TSIZE_W+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_mag[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (r_busy) begin
            if (!diff[TSIZE_W+1]) begin
                n_rem = diff[TSIZE_W-1:0];
                n_mag = {r_mag[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[TSIZE_W-1:0];
                n_mag = {r_mag[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_mag <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule
`default_nettype wire

// ===== hdl/tile_grid_box_collision.sv =====
`default_nettype none
// Channel   | Direction | Handshake                       | Payload
// config    | in        | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
// request   | in        | i_in_valid / o_in_ready         | i_action .. i_box_max_y
// response  | out       | o_out_valid / i_out_ready       | o_tile_value, o_solid, o_blocked, o_hit
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells runs before the first request.
// Writes pass through the ADDR and OP states; reads go on through RD_DONE and RESULT to the response.
// A box test on an enabled grid runs four divisions in turn on one shared divider, then checks
// each covered cell via CELL_ADDR, CELL_READ and CELL_CHECK, stopping at the first blocking hit.
// Configuration transactions are taken in every cycle.
// A waiting response does not block the next request until that request's result is ready.
module tile_grid_box_collision #(
    parameter int MAX_WIDTH  = tgbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tgbc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [tgbc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tgbc_pkg::COORD_W-1:0]           i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [2:0]                             i_action,
    input  wire logic signed [tgbc_pkg::CELL_W-1:0]     i_cell_x,
    input  wire logic signed [tgbc_pkg::CELL_W-1:0]     i_cell_y,
    input  wire logic signed [tgbc_pkg::TILE_W-1:0]     i_atlas_index,
    input  wire logic                                   i_solid_flag,
    input  wire logic signed [tgbc_pkg::COORD_W-1:0]    i_box_min_x,
    input  wire logic signed [tgbc_pkg::COORD_W-1:0]    i_box_min_y,
    input  wire logic signed [tgbc_pkg::COORD_W-1:0]    i_box_max_x,
    input  wire logic signed [tgbc_pkg::COORD_W-1:0]    i_box_max_y,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [tgbc_pkg::TILE_W-1:0]          o_tile_value,
    output logic                                        o_solid,
    output logic                                        o_blocked,
    output logic                                        o_hit
);
    import tgbc_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W = YW + DIM_W + 1;

    t_state r_state, n_state;

    logic signed [COORD_W-1:0]  r_ox, r_oy;
    logic [TSIZE_W-1:0]         r_tw, r_th;
    logic [MAPDIM_W-1:0]        r_mw, r_mh;

    logic [2:0]                 r_act;
    logic signed [CELL_W-1:0]   r_cx, r_cy;
    logic signed [TILE_W-1:0]   r_atlas;
    logic                       r_sflag;
    logic signed [WIDE_W-1:0]   r_bx0, r_by0, r_bx1, r_by1;

    logic [TILE_W-1:0]          tile_mem [CELLS];
    logic                       solid_mem [CELLS];
    logic [TILE_W-1:0]          r_tile_q;
    logic                       r_solid_q;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_inr, n_inr;
    logic [AW-1:0]              r_clr;

    logic [1:0]                 r_k;
    logic signed [QUO_W-1:0]    r_q [4];
    logic [XW-1:0]              r_x, r_sx, r_ex;
    logic [YW-1:0]              r_y, r_ey;
    logic [XW-1:0]              n_x;
    logic [YW-1:0]              n_y;
    logic [XW-1:0]              n_sx, n_ex;
    logic [YW-1:0]              n_ey;
    logic signed [WIDE_W-1:0]   r_px, r_py;
    logic signed [WIDE_W-1:0]   r_tx0, r_tx1, r_ty0, r_ty1;

    logic signed [TILE_W-1:0]   r_res_tile, n_res_tile;
    logic                       r_res_solid, n_res_solid;
    logic                       r_res_blk, n_res_blk;
    logic                       r_res_hit, n_res_hit;
    logic                       r_out_valid;
    logic signed [TILE_W-1:0]   r_out_tile;
    logic                       r_out_solid, r_out_blk, r_out_hit;

    logic [DIM_W-1:0]           ew, eh;
    logic                       disabled;
    logic                       accept_in, load_out;
    logic                       mem_we_tile, mem_we_solid;
    logic [AW-1:0]              mem_waddr;
    logic [TILE_W-1:0]          mem_wtile;
    logic                       mem_wsolid;
    logic [PROD_W-1:0]          slot_cell, slot_walk;
    logic                       inr_cell;
    logic                       div_start;
    logic                       div_done;
    logic signed [NUM_W-1:0]    div_num;
    logic [TSIZE_W-1:0]         div_den;
    logic signed [QUO_W-1:0]    div_quo;
    logic signed [QUO_W-1:0]    sxc, exc, syc, eyc, ewm1, ehm1;
    logic                       cell_blocks, overlap;

    assign ew = ({2'b00, r_mw} > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : {2'b00, r_mw};
    assign eh = ({2'b00, r_mh} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : {2'b00, r_mh};
    assign disabled = (r_tw == '0) || (r_th == '0) || (ew == '0) || (eh == '0);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept_in   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
            r_tw <= TSIZE_W'(65536);
            r_th <= TSIZE_W'(65536);
            r_mw <= '0;
            r_mh <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:    r_ox <= i_cfg_data;
                CFG_ORIGIN_Y:    r_oy <= i_cfg_data;
                CFG_TILE_WIDTH:  r_tw <= i_cfg_data[TSIZE_W-1:0];
                CFG_TILE_HEIGHT: r_th <= i_cfg_data[TSIZE_W-1:0];
                CFG_MAP_WIDTH:   r_mw <= i_cfg_data[MAPDIM_W-1:0];
                CFG_MAP_HEIGHT:  r_mh <= i_cfg_data[MAPDIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_act   <= i_action;
            r_cx    <= i_cell_x;
            r_cy    <= i_cell_y;
            r_atlas <= i_atlas_index;
            r_sflag <= i_solid_flag;
            r_bx0   <= WIDE_W'(i_box_min_x);
            r_by0   <= WIDE_W'(i_box_min_y);
            r_bx1   <= WIDE_W'(i_box_max_x);
            r_by1   <= WIDE_W'(i_box_max_y);
        end
    end

    assign inr_cell = !r_cx[CELL_W-1] && !r_cy[CELL_W-1]
                      && (DIM_W'(r_cx[CELL_W-2:0]) < ew)
                      && (DIM_W'(r_cy[CELL_W-2:0]) < eh);
    assign slot_cell = PROD_W'(YW'(r_cy[CELL_W-2:0])) * PROD_W'(ew)
                       + PROD_W'(XW'(r_cx[CELL_W-2:0]));
    assign slot_walk = PROD_W'(r_y) * PROD_W'(ew) + PROD_W'(r_x);

    always_comb begin
        mem_we_tile  = 1'b0;
        mem_we_solid = 1'b0;
        mem_waddr    = r_addr;
        mem_wtile    = r_atlas;
        mem_wsolid   = r_sflag;
        if (r_state == ST_CLEAR) begin
            mem_we_tile  = 1'b1;
            mem_we_solid = 1'b1;
            mem_waddr    = r_clr;
            mem_wtile    = '1;
            mem_wsolid   = 1'b0;
        end else if (r_state == ST_OP && r_inr) begin
            mem_we_tile  = (r_act == ACT_WR_TILE);
            mem_we_solid = (r_act == ACT_WR_SOLID);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we_tile) begin
            tile_mem[mem_waddr] <= mem_wtile;
        end
        r_tile_q <= tile_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we_solid) begin
            solid_mem[mem_waddr] <= mem_wsolid;
        end
        r_solid_q <= solid_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_comb begin
        unique case (r_k)
            2'd0:    div_num = $signed({r_bx0[COORD_W-1], r_bx0[COORD_W-1:0]})
                               - $signed({r_ox[COORD_W-1], r_ox});
            2'd1:    div_num = $signed({r_bx1[COORD_W-1], r_bx1[COORD_W-1:0]})
                               - $signed({r_ox[COORD_W-1], r_ox});
            2'd2:    div_num = $signed({r_oy[COORD_W-1], r_oy})
                               - $signed({r_by1[COORD_W-1], r_by1[COORD_W-1:0]});
            default: div_num = $signed({r_oy[COORD_W-1], r_oy})
                               - $signed({r_by0[COORD_W-1], r_by0[COORD_W-1:0]});
        endcase
        div_den = r_k[1] ? r_th : r_tw;
    end

    assign div_start = (r_state == ST_DIV_LOAD);

    tgbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_q[r_k] <= div_quo;
        end
    end

    assign ewm1 = QUO_W'(ew) - QUO_W'(1);
    assign ehm1 = QUO_W'(eh) - QUO_W'(1);
    assign sxc  = r_q[0][QUO_W-1] ? '0 : r_q[0];
    assign exc  = (r_q[1] > ewm1) ? ewm1 : r_q[1];
    assign syc  = r_q[2][QUO_W-1] ? '0 : r_q[2];
    assign eyc  = (r_q[3] > ehm1) ? ehm1 : r_q[3];
    assign n_sx = XW'(sxc);
    assign n_ex = XW'(exc);
    assign n_ey = YW'(eyc);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CELL_ADDR) begin
            r_px <= $signed(WIDE_W'(r_x) * WIDE_W'(r_tw));
            r_py <= $signed(WIDE_W'(r_y) * WIDE_W'(r_th));
        end
        if (r_state == ST_CELL_READ) begin
            r_tx0 <= WIDE_W'(r_ox) + r_px;
            r_tx1 <= WIDE_W'(r_ox) + r_px + $signed(WIDE_W'(r_tw));
            r_ty1 <= WIDE_W'(r_oy) - r_py;
            r_ty0 <= WIDE_W'(r_oy) - r_py - $signed(WIDE_W'(r_th));
        end
    end

    assign cell_blocks = !r_tile_q[TILE_W-1] && r_solid_q;
    assign overlap = (r_bx0 <= r_tx1) && (r_bx1 >= r_tx0)
                     && (r_by0 <= r_ty1) && (r_by1 >= r_ty0);

    assign load_out = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_inr       = r_inr;
        n_x         = r_x;
        n_y         = r_y;
        n_res_tile  = r_res_tile;
        n_res_solid = r_res_solid;
        n_res_blk   = r_res_blk;
        n_res_hit   = r_res_hit;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept_in) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_addr      = AW'(slot_cell);
                n_inr       = inr_cell;
                n_res_tile  = '1;
                n_res_solid = 1'b0;
                n_res_blk   = 1'b0;
                n_res_hit   = 1'b0;
                case (r_act)
                    ACT_WR_TILE, ACT_WR_SOLID, ACT_RD_TILE, ACT_RD_BLOCK:
                        n_state = ST_OP;
                    ACT_BOX:
                        n_state = disabled ? ST_RESULT : ST_DIV_LOAD;
                    default:
                        n_state = ST_IDLE;
                endcase
            end
            ST_OP: begin
                if (r_act == ACT_WR_TILE || r_act == ACT_WR_SOLID) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD_DONE;
                end
            end
            ST_RD_DONE: begin
                if (r_inr) begin
                    n_res_tile  = r_tile_q;
                    n_res_solid = r_solid_q;
                    n_res_blk   = cell_blocks;
                end
                n_state = ST_RESULT;
            end
            ST_DIV_LOAD: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_k == 2'd3) ? ST_CLAMP : ST_DIV_LOAD;
                end
            end
            ST_CLAMP: begin
                n_x = n_sx;
                n_y = YW'(syc);
                if (sxc > exc || syc > eyc) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_CELL_ADDR;
                end
            end
            ST_CELL_ADDR: begin
                n_addr  = AW'(slot_walk);
                n_state = ST_CELL_READ;
            end
            ST_CELL_READ: begin
                n_state = ST_CELL_CHECK;
            end
            ST_CELL_CHECK: begin
                if (cell_blocks && overlap) begin
                    n_res_hit = 1'b1;
                    n_state   = ST_RESULT;
                end else if (r_x == r_ex) begin
                    if (r_y == r_ey) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_y     = r_y + YW'(1);
                        n_x     = r_sx;
                        n_state = ST_CELL_ADDR;
                    end
                end else begin
                    n_x     = r_x + XW'(1);
                    n_state = ST_CELL_ADDR;
                end
            end
            ST_RESULT: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ADDR) begin
                r_k <= '0;
            end else if (r_state == ST_DIV_WAIT && div_done) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_inr       <= n_inr;
        r_x         <= n_x;
        r_y         <= n_y;
        r_res_tile  <= n_res_tile;
        r_res_solid <= n_res_solid;
        r_res_blk   <= n_res_blk;
        r_res_hit   <= n_res_hit;
        if (r_state == ST_CLAMP) begin
            r_sx <= n_sx;
            r_ex <= n_ex;
            r_ey <= n_ey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_tile  <= r_res_tile;
            r_out_solid <= r_res_solid;
            r_out_blk   <= r_res_blk;
            r_out_hit   <= r_res_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tile_value = r_out_tile;
    assign o_solid      = r_out_solid;
    assign o_blocked    = r_out_blk;
    assign o_hit        = r_out_hit;

endmodule
`default_nettype wire
